### src/fcetn_pkg.sv
// Package for the fuzzy cross-entropy top-N search block.
// Holds widths, request codes, the empty-slot sentinel and shared structs.
// No dependencies; every other file of the block but fcetn_ram imports it.
package fcetn_pkg;

  // Size of the best list and the index that walks it.
  localparam int unsigned MAX_N  = 64;
  localparam int unsigned IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  // Field widths.
  localparam int unsigned TOPN_W = 7;
  localparam int unsigned RANK_W = 6;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned LOG_W  = 24;
  localparam int unsigned DIST_W = 48;
  localparam int unsigned ID_W   = 20;
  localparam int unsigned FRAC_W = 16;

  // Operands of the shared multiplier: 1-v needs one bit more than v,
  // a difference of two logs needs one bit more than a log.
  localparam int unsigned OPA_W  = VAL_W + 1;
  localparam int unsigned OPB_W  = LOG_W + 1;
  localparam int unsigned PROD_W = OPA_W + OPB_W;

  localparam logic [OPA_W-1:0] ONE_Q16 = OPA_W'(1) << FRAC_W;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ELEM  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Register reset value and the largest meaningful setting.
  localparam logic [TOPN_W-1:0] TOP_N_RST = 7'd10;
  localparam logic [TOPN_W-1:0] TOP_N_MAX = TOPN_W'(MAX_N);

  // Distance reported by an empty slot: 99999 in Q.16.
  localparam logic signed [DIST_W-1:0] SENTINEL_DIST = DIST_W'(64'd99999 << FRAC_W);

  // One list entry as stored in the list memory.
  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [ID_W-1:0]          id;
  } entry_t;

  localparam int unsigned ENTRY_W = DIST_W + ID_W;

  // Controls of the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clr;
  } mac_ctrl_t;

endpackage

### src/fcetn_req_if.sv
// Request channel of the fuzzy cross-entropy top-N search block.
// Carries valid, ready and one request; depends on fcetn_pkg.
interface fcetn_req_if;
  import fcetn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [VAL_W-1:0]        query_value;
  logic signed [LOG_W-1:0] query_log;
  logic signed [LOG_W-1:0] query_log_complement;
  logic signed [LOG_W-1:0] cand_log;
  logic signed [LOG_W-1:0] cand_log_complement;
  logic [ID_W-1:0]         candidate_index;
  logic                    last_element;

  modport source (
    output valid, req_type, query_value, query_log, query_log_complement,
           cand_log, cand_log_complement, candidate_index, last_element,
    input  ready
  );

  modport sink (
    input  valid, req_type, query_value, query_log, query_log_complement,
           cand_log, cand_log_complement, candidate_index, last_element,
    output ready
  );

endinterface

### src/fcetn_res_if.sv
// Result channel of the fuzzy cross-entropy top-N search block.
// Carries valid, ready and one ranked list entry; depends on fcetn_pkg.
interface fcetn_res_if;
  import fcetn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [RANK_W-1:0]        rank;
  logic signed [DIST_W-1:0] distance;
  logic [ID_W-1:0]          best_candidate;
  logic                     slot_used;
  logic                     last_result;

  modport source (
    output valid, rank, distance, best_candidate, slot_used, last_result,
    input  ready
  );

  modport sink (
    input  valid, rank, distance, best_candidate, slot_used, last_result,
    output ready
  );

endinterface

### src/fcetn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fcetn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/fcetn_mac.sv
// Shared multiply-accumulate unit of the fuzzy cross-entropy top-N search.
// One registered multiplier, floor to Q.16, 48-bit wrapping running sum.
// Depends on fcetn_pkg.
module fcetn_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcetn_pkg::mac_ctrl_t                ctrl_i,
  input  logic [fcetn_pkg::OPA_W-1:0]         op_a_i,
  input  logic signed [fcetn_pkg::OPB_W-1:0]  op_b_i,
  output logic signed [fcetn_pkg::DIST_W-1:0] sum_o
);
  import fcetn_pkg::*;

  logic signed [OPA_W:0]               op_a_s;
  logic signed [PROD_W-1:0]            prod_d, prod_q;
  logic signed [PROD_W-FRAC_W-1:0]     term;
  logic signed [DIST_W-1:0]            sum_d, sum_q;

  // Multiply: the unsigned weight gets a zero sign bit.
  assign op_a_s = {1'b0, op_a_i};
  assign prod_d = PROD_W'(op_a_s) * PROD_W'(op_b_i);

  // Dropping the fraction bits of a two's complement product floors it.
  assign term = $signed(prod_q[PROD_W-1:FRAC_W]);

  // Running sum wraps modulo 2^48.
  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.acc_en) begin
      sum_d = sum_q + DIST_W'(term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Product register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### src/fuzzy_cross_entropy_top_n.sv
// Fuzzy cross-entropy top-N search: a start request empties the list and clears
// the sum; an element passes through MUL2 and ACC on the shared multiplier, and the
// last element of a candidate adds FIN and an insertion scan of INS_RD and INS_CMP per
// list slot, up to the first empty slot or the active length. A read request walks
// RD_RD and RD_OUT per rank through the list memory read port; sink stalls hold RD_OUT.
// After reset the list is empty, top_n is 10 and requests are taken at once.
module fuzzy_cross_entropy_top_n (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcetn_pkg::TOPN_W-1:0]      cfg_wdata_i,
  fcetn_req_if.sink                         req_i,
  fcetn_res_if.source                       res_o
);
  import fcetn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL2,
    ST_ACC,
    ST_FIN,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RD_RD,
    ST_RD_OUT
  } state_e;

  state_e                   state_d, state_q;
  logic [TOPN_W-1:0]        top_n_d, top_n_q;
  logic [TOPN_W-1:0]        n_act;
  logic [IDX_W-1:0]         idx_d, idx_q;
  logic [MAX_N-1:0]         used_d, used_q;
  logic [MAX_N-1:0]         used_inc;
  logic                     placed_d, placed_q;
  logic                     last_d, last_q;
  logic                     carry_used_d, carry_used_q;
  entry_t                   carry_d, carry_q;
  logic [VAL_W-1:0]         v_d, v_q;
  logic signed [OPB_W-1:0]  diff2_d, diff2_q;
  logic [ID_W-1:0]          id_d, id_q;

  logic                     res_valid_d, res_valid_q;
  logic [RANK_W-1:0]        rank_d, rank_q;
  logic signed [DIST_W-1:0] dist_d, dist_q;
  logic [ID_W-1:0]          best_d, best_q;
  logic                     slot_used_d, slot_used_q;
  logic                     last_res_d, last_res_q;

  mac_ctrl_t                mac_ctrl;
  logic [OPA_W-1:0]         op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [DIST_W-1:0] sum;

  logic                     ram_we;
  entry_t                   ram_rdata;
  entry_t                   slot;
  logic                     slot_used;
  logic                     idx_last;
  logic                     take;
  logic                     out_free;
  logic                     req_xfer;

  // Effective list length: zero acts as one, larger than the list as full list.
  always_comb begin
    if (top_n_q == '0) begin
      n_act = TOPN_W'(1);
    end else if (top_n_q > TOP_N_MAX) begin
      n_act = TOP_N_MAX;
    end else begin
      n_act = top_n_q;
    end
  end

  assign idx_last = (TOPN_W'(idx_q) + TOPN_W'(1)) == n_act;
  assign req_xfer = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free = !res_valid_q || res_o.ready;

  // An empty slot reads as the sentinel with identifier zero.
  assign slot_used = used_q[idx_q];
  always_comb begin
    if (slot_used) begin
      slot = ram_rdata;
    end else begin
      slot.distance = SENTINEL_DIST;
      slot.id       = '0;
    end
  end

  // Once the new entry is placed, every later slot takes the displaced one.
  assign take   = placed_q || (carry_q.distance < slot.distance);
  assign ram_we = (state_q == ST_INS_CMP) && take;

  // Operand selection for the shared multiplier.
  always_comb begin
    if (state_q == ST_IDLE) begin
      op_a = {1'b0, req_i.query_value};
      op_b = OPB_W'(req_i.query_log) - OPB_W'(req_i.cand_log);
    end else begin
      op_a = ONE_Q16 - {1'b0, v_q};
      op_b = diff2_q;
    end
  end

  // Sequencer next-state and datapath control.
  always_comb begin
    state_d      = state_q;
    top_n_d      = top_n_q;
    idx_d        = idx_q;
    used_d       = used_q;
    placed_d     = placed_q;
    last_d       = last_q;
    carry_d      = carry_q;
    carry_used_d = carry_used_q;
    v_d          = v_q;
    diff2_d      = diff2_q;
    id_d         = id_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    rank_d       = rank_q;
    dist_d       = dist_q;
    best_d       = best_q;
    slot_used_d  = slot_used_q;
    last_res_d   = last_res_q;
    mac_ctrl     = '0;

    if (cfg_we_i) begin
      top_n_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          case (req_i.req_type)
            REQ_START: begin
              used_d       = '0;
              mac_ctrl.clr = 1'b1;
            end
            REQ_ELEM: begin
              mac_ctrl.mul_en = 1'b1;
              v_d     = req_i.query_value;
              diff2_d = OPB_W'(req_i.query_log_complement)
                      - OPB_W'(req_i.cand_log_complement);
              id_d    = req_i.candidate_index;
              last_d  = req_i.last_element;
              state_d = ST_MUL2;
            end
            REQ_READ: begin
              idx_d   = '0;
              state_d = ST_RD_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // Take the finished distance and restart the sum.
        mac_ctrl.clr     = 1'b1;
        carry_d.distance = sum;
        carry_d.id       = id_q;
        carry_used_d     = 1'b1;
        placed_d         = 1'b0;
        idx_d            = '0;
        state_d          = ST_INS_RD;
      end
      ST_INS_RD: begin
        state_d = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (take) begin
          used_d[idx_q] = carry_used_q;
          carry_d       = slot;
          carry_used_d  = slot_used;
          placed_d      = 1'b1;
        end
        // Past the first empty slot nothing changes.
        if (idx_last || !slot_used) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_INS_RD;
        end
      end
      ST_RD_RD: begin
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          res_valid_d = 1'b1;
          rank_d      = RANK_W'(idx_q);
          dist_d      = slot.distance;
          best_d      = slot.id;
          slot_used_d = slot_used;
          last_res_d  = idx_last;
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and registered result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_n_q     <= TOP_N_RST;
      used_q      <= '0;
      placed_q    <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_n_q     <= top_n_d;
      used_q      <= used_d;
      placed_q    <= placed_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    carry_q      <= carry_d;
    carry_used_q <= carry_used_d;
    v_q          <= v_d;
    diff2_q      <= diff2_d;
    id_q         <= id_d;
    rank_q       <= rank_d;
    dist_q       <= dist_d;
    best_q       <= best_d;
    slot_used_q  <= slot_used_d;
    last_res_q   <= last_res_d;
  end

  fcetn_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .sum_o  (sum)
  );

  fcetn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_N)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (carry_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid          = res_valid_q;
  assign res_o.rank           = rank_q;
  assign res_o.distance       = dist_q;
  assign res_o.best_candidate = best_q;
  assign res_o.slot_used      = slot_used_q;
  assign res_o.last_result    = last_res_q;

  // Occupied slots always form a contiguous run from rank zero.
  assign used_inc = used_q + MAX_N'(1);

  a_used_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_inc & used_q) == '0)
    else $error("occupied slots are not contiguous from rank zero");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && req_i.req_type == REQ_START) |=> (used_q == '0))
    else $error("start transfer did not empty the list");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (TOPN_W'(idx_q) < n_act))
    else $error("list write beyond the active length");

  a_insert_begins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (!placed_q && idx_q == '0 && carry_used_q))
    else $error("insertion scan did not start at rank zero");

endmodule
